[rtl/pst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process slot table scheduler package
// Shared sizes, operation and slot state codes, table write bundle.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int PROCESS_SLOTS = 8;
  localparam int SLOT_W        = (PROCESS_SLOTS > 2) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int ID_W          = 31;
  localparam int IDX_W         = 3;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_SCHED   = 2'd2,
    FN_REQUEUE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    logic              st_en;
    status_t           status;
    logic              id_en;
    logic [ID_W-1:0]   id;
  } tbl_wr_t;

endpackage

[rtl/pst_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process slot table
// Per-slot state and id registers with one shared read/write index.
// ----------------------------------------------------------------------------
module pst_slot_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pst_pkg::SLOT_W-1:0] idx,
  input  pst_pkg::tbl_wr_t          wr,
  output pst_pkg::status_t          rd_status,
  output logic [pst_pkg::ID_W-1:0]  rd_id
);

  pst_pkg::status_t          status_r [pst_pkg::PROCESS_SLOTS];
  logic [pst_pkg::ID_W-1:0]  id_r     [pst_pkg::PROCESS_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pst_pkg::PROCESS_SLOTS; k++) begin
        status_r[k] <= pst_pkg::ST_FREE;
        id_r[k]     <= '0;
      end
    end else begin
      if (wr.st_en) begin
        status_r[idx] <= wr.status;
      end
      if (wr.id_en) begin
        id_r[idx] <= wr.id;
      end
    end
  end

  assign rd_status = status_r[idx];
  assign rd_id     = id_r[idx];

endmodule

[rtl/process_slot_table_scheduler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process slot table scheduler core
// Allocate, release, round-robin schedule and requeue over a slot table,
// one slot examined per cycle by a single compare step.
// ----------------------------------------------------------------------------
// Channel   Ports                              Direction  Word
// input     in_valid/in_ready                  in         in_func, in_slot_index
// result    out_valid/out_ready                out        out_found, out_slot_out, out_id_out
//
// Allocate and schedule visit one slot per cycle, up to PROCESS_SLOTS slots in
// the scan, then hold the registered result in the output state.
// Release and requeue do their work in the execute state, then register the result.
// in_ready is high only while idle; a stalled result holds the block.
// Reset (synchronous) frees all slots, clears ids, sets the id counter to 1.
// ----------------------------------------------------------------------------
module process_slot_table_scheduler_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [2:0]                in_slot_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [2:0]                out_slot_out,
  output logic [30:0]               out_id_out
);

  localparam int SW  = pst_pkg::SLOT_W;
  localparam int IW  = pst_pkg::ID_W;
  localparam int CW  = $clog2(pst_pkg::PROCESS_SLOTS + 1) + pst_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  pst_pkg::func_t          func_r, func_nxt;
  logic [SW-1:0]           ptr_r, ptr_nxt;
  logic [SW-1:0]           cnt_r, cnt_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic                    range_r, range_nxt;
  logic [IW-1:0]           next_id_r, next_id_nxt;
  logic                    cur_valid_r, cur_valid_nxt;
  logic [SW-1:0]           cur_r, cur_nxt;
  logic                    found_r, found_nxt;
  logic [2:0]              slot_r, slot_nxt;
  logic [IW-1:0]           id_r, id_nxt;

  pst_pkg::tbl_wr_t        wr;
  pst_pkg::status_t        rd_status;
  logic [IW-1:0]           rd_id;
  logic                    last;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] s);
    wrap_inc = (s == SW'(pst_pkg::PROCESS_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  pst_slot_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .idx       (ptr_r),
    .wr        (wr),
    .rd_status (rd_status),
    .rd_id     (rd_id)
  );

  assign last = (cnt_r == SW'(pst_pkg::PROCESS_SLOTS - 1));

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    range_nxt     = range_r;
    next_id_nxt   = next_id_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    id_nxt        = id_r;
    wr            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = pst_pkg::func_t'(in_func);
          idx_nxt   = in_slot_index;
          range_nxt = ({{(CW - 3){1'b0}}, in_slot_index} < CW'(pst_pkg::PROCESS_SLOTS));
          cnt_nxt   = '0;
          case (pst_pkg::func_t'(in_func))
            pst_pkg::FN_ALLOC: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            pst_pkg::FN_SCHED: begin
              ptr_nxt   = cur_valid_r ? wrap_inc(cur_r) : '0;
              state_nxt = S_SCAN;
            end
            default: begin
              ptr_nxt   = SW'(in_slot_index);
              state_nxt = S_EXEC;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (func_r == pst_pkg::FN_ALLOC && rd_status == pst_pkg::ST_FREE) begin
          wr.st_en    = 1'b1;
          wr.status   = pst_pkg::ST_READY;
          wr.id_en    = 1'b1;
          wr.id       = next_id_r;
          next_id_nxt = (next_id_r == '1) ? IW'(1) : next_id_r + 1'b1;
          found_nxt   = 1'b1;
          slot_nxt    = 3'(ptr_r);
          id_nxt      = next_id_r;
          state_nxt   = S_OUT;
        end else if (func_r == pst_pkg::FN_SCHED && rd_status == pst_pkg::ST_READY) begin
          wr.st_en      = 1'b1;
          wr.status     = pst_pkg::ST_RUNNING;
          cur_nxt       = ptr_r;
          cur_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          slot_nxt      = 3'(ptr_r);
          id_nxt        = rd_id;
          state_nxt     = S_OUT;
        end else if (last) begin
          found_nxt = 1'b0;
          slot_nxt  = '0;
          id_nxt    = '0;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = wrap_inc(ptr_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_EXEC: begin
        slot_nxt  = idx_r;
        state_nxt = S_OUT;
        if (!range_r) begin
          found_nxt = 1'b0;
          id_nxt    = '0;
        end else if (func_r == pst_pkg::FN_RELEASE) begin
          wr.st_en  = 1'b1;
          wr.status = pst_pkg::ST_FREE;
          wr.id_en  = 1'b1;
          wr.id     = '0;
          found_nxt = 1'b1;
          id_nxt    = '0;
        end else if (rd_status == pst_pkg::ST_FREE) begin
          found_nxt = 1'b0;
          id_nxt    = '0;
        end else begin
          wr.st_en  = 1'b1;
          wr.status = pst_pkg::ST_READY;
          found_nxt = 1'b1;
          id_nxt    = rd_id;
        end
      end

      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= IW'(1);
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    ptr_r   <= ptr_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    range_r <= range_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    id_r    <= id_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_found    = found_r;
  assign out_slot_out = slot_r;
  assign out_id_out   = id_r;

endmodule
